FILE: hdl/cps_pkg.sv
`default_nettype none

package cps_pkg;

  // Block configuration.
  localparam int NUM_SOURCES        = 4;
  localparam int TARGETS_PER_SOURCE = 16;
  localparam int ADDR_BITS          = 48;

  // Fixed constants of the selection scheme.
  localparam int LINE_BYTES = 8;
  localparam int DECAY_DIV  = 10;
  localparam int COUNT_W    = 32;
  localparam int REG_W      = 16;

  // Divide by DECAY_DIV as a multiply by ceil(2^35 / 10) and a right shift by 35.
  // The pair is exact for every COUNT_W-bit count.
  localparam logic [COUNT_W-1:0] DECAY_RECIP = 32'hCCCC_CCCD;
  localparam int                 DECAY_SHIFT = 35;

  // Derived widths.
  localparam int SID_W   = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam int IDX_W   = (TARGETS_PER_SOURCE > 1) ? $clog2(TARGETS_PER_SOURCE) : 1;
  localparam int FILL_W  = $clog2(TARGETS_PER_SOURCE + 1);
  localparam int MEM_DEPTH = NUM_SOURCES * TARGETS_PER_SOURCE;
  localparam int MEM_AW  = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  // Operation codes of the op field.
  localparam logic OP_ACCESS = 1'b0;
  localparam logic OP_TARGET = 1'b1;

  // Configuration register indexes.
  localparam int   CFG_IDX_W       = 1;
  localparam logic CFG_WINDOW_SIZE  = 1'b0;
  localparam logic CFG_SWITCH_DELAY = 1'b1;

  // Input beat.
  typedef struct packed {
    logic                 op;
    logic [1:0]           source_index;
    logic [ADDR_BITS-1:0] address;
  } cps_in_t;

  // Result beat.
  typedef struct packed {
    logic [1:0] chosen;
    logic       decided;
    logic       evaluating;
  } cps_out_t;

  // Status of the decay divider.
  typedef struct packed {
    logic busy;
    logic done;
  } cps_div_stat_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_WIN,
    ST_DEC_START,
    ST_DEC_WAIT,
    ST_SELECT,
    ST_FINISH
  } cps_state_t;

endpackage

`default_nettype wire

FILE: hdl/cps_target_buf.sv
`default_nettype none

module cps_target_buf (
  input  wire logic                          clk,
  input  wire logic                          wr_en,
  input  wire logic [cps_pkg::MEM_AW-1:0]    wr_addr,
  input  wire logic [cps_pkg::ADDR_BITS-1:0] wr_data,
  input  wire logic                          rd_en,
  input  wire logic [cps_pkg::MEM_AW-1:0]    rd_addr,
  output logic      [cps_pkg::ADDR_BITS-1:0] rd_data
);
  import cps_pkg::*;

  logic [ADDR_BITS-1:0] mem [MEM_DEPTH];

  // Single write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/cps_decay_unit.sv
`default_nettype none

module cps_decay_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [cps_pkg::COUNT_W-1:0] value,
  output cps_pkg::cps_div_stat_t           stat,
  output logic      [cps_pkg::COUNT_W-1:0] quotient
);
  import cps_pkg::*;

  logic [2*COUNT_W-1:0] prod_r, prod_nxt;
  logic [COUNT_W-1:0]   q_r, q_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;

  // The product by the scaled reciprocal is registered first, and the registered
  // product is then shifted down into the quotient register.
  always_comb begin
    prod_nxt = prod_r;
    q_nxt    = q_r;
    busy_nxt = 1'b0;
    done_nxt = 1'b0;
    if (start) begin
      prod_nxt = value * DECAY_RECIP;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt    = COUNT_W'(prod_r[2*COUNT_W-1:DECAY_SHIFT]);
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    q_r    <= q_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = q_r;

endmodule

`default_nettype wire

FILE: hdl/coverage_prefetcher_selector_core.sv
`default_nettype none

// Prefetcher selector. A target beat goes from idle straight to the finish
// state. An access beat passes the window and select states; while an
// evaluation is pending it first passes the scan and drain states, as every
// entry of the target buffer is read through its one read port and each
// buffered target compared, one entry per cycle. An access that ends a window
// also runs the divide-by-ten of each useful count, done as a registered
// multiply by the scaled reciprocal followed by a shift. The input is stalled
// while a beat is in work; the result waits in an output register.
// Configuration writes are always ready and take effect at once.
module coverage_prefetcher_selector_core (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire cps_pkg::cps_in_t                   in_data,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output cps_pkg::cps_out_t                       out_data,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [cps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [cps_pkg::REG_W-1:0]          cfg_data
);
  import cps_pkg::*;

  cps_state_t           state_r, state_nxt;
  logic [ADDR_BITS-1:0] addr_r, addr_nxt;
  logic [REG_W-1:0]     access_count_r, access_count_nxt;
  logic                 pending_r, pending_nxt;
  logic [1:0]           selected_r, selected_nxt;
  logic [COUNT_W-1:0]   useful_r [NUM_SOURCES];
  logic [COUNT_W-1:0]   useful_nxt [NUM_SOURCES];
  logic [FILL_W-1:0]    fill_r [NUM_SOURCES];
  logic [FILL_W-1:0]    fill_nxt [NUM_SOURCES];
  logic [SID_W-1:0]     scan_s_r, scan_s_nxt;
  logic [IDX_W-1:0]     scan_i_r, scan_i_nxt;
  logic                 pipe_vld_r, pipe_vld_nxt;
  logic [SID_W-1:0]     pipe_src_r, pipe_src_nxt;
  logic                 pipe_ok_r, pipe_ok_nxt;
  logic [SID_W-1:0]     dsrc_r, dsrc_nxt;
  logic                 dec_r, dec_nxt;
  logic [REG_W-1:0]     window_size_r, window_size_nxt;
  logic [REG_W-1:0]     switch_delay_r, switch_delay_nxt;
  logic                 out_valid_r, out_valid_nxt;
  cps_out_t             out_data_r, out_data_nxt;

  logic                 in_accept;
  logic [SID_W-1:0]     in_sid;
  logic                 in_src_ok;
  logic [SID_W-1:0]     fill_idx;
  logic [FILL_W-1:0]    fill_cur;
  logic [SID_W-1:0]     cnt_idx;
  logic [COUNT_W-1:0]   cnt_cur;
  logic [ADDR_BITS-1:0] rd_data;
  logic [ADDR_BITS-1:0] diff;
  logic                 hit;
  logic                 wr_en;
  logic [MEM_AW-1:0]    wr_addr;
  logic                 rd_en;
  logic [MEM_AW-1:0]    rd_addr;
  logic                 div_start;
  cps_div_stat_t        div_stat;
  logic [COUNT_W-1:0]   div_quot;
  logic [COUNT_W-1:0]   best;
  logic [1:0]           best_idx;
  logic                 out_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign in_sid    = SID_W'(in_data.source_index);
  assign in_src_ok = (32'(in_data.source_index) < NUM_SOURCES);

  // One shared read of the fill counts and one of the useful counts for the increment.
  assign fill_idx = (state_r == ST_IDLE) ? in_sid : scan_s_r;
  assign fill_cur = fill_r[fill_idx];
  assign cnt_idx  = (state_r == ST_DEC_WAIT) ? dsrc_r : pipe_src_r;
  assign cnt_cur  = useful_r[cnt_idx];

  // Line test on the buffered target read in the previous cycle.
  assign diff = addr_r - rd_data;
  assign hit  = pipe_vld_r && pipe_ok_r && (addr_r >= rd_data) &&
                (diff < ADDR_BITS'(LINE_BYTES));

  // Strictly greatest nonzero count, earliest source on ties.
  always_comb begin
    best     = '0;
    best_idx = selected_r;
    for (int s = 0; s < NUM_SOURCES; s++) begin
      if (useful_r[s] > best) begin
        best     = useful_r[s];
        best_idx = 2'(s);
      end
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt        = state_r;
    addr_nxt         = addr_r;
    access_count_nxt = access_count_r;
    pending_nxt      = pending_r;
    selected_nxt     = selected_r;
    useful_nxt       = useful_r;
    fill_nxt         = fill_r;
    scan_s_nxt       = scan_s_r;
    scan_i_nxt       = scan_i_r;
    pipe_vld_nxt     = 1'b0;
    pipe_src_nxt     = pipe_src_r;
    pipe_ok_nxt      = pipe_ok_r;
    dsrc_nxt         = dsrc_r;
    dec_nxt          = dec_r;
    window_size_nxt  = window_size_r;
    switch_delay_nxt = switch_delay_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_data_nxt     = out_data_r;
    wr_en            = 1'b0;
    wr_addr          = MEM_AW'(32'(in_sid) * TARGETS_PER_SOURCE + 32'(fill_cur));
    rd_en            = 1'b0;
    rd_addr          = MEM_AW'(32'(scan_s_r) * TARGETS_PER_SOURCE + 32'(scan_i_r));
    div_start        = 1'b0;

    // Configuration writes.
    if (cfg_valid) begin
      case (cfg_index)
        CFG_WINDOW_SIZE:  window_size_nxt  = cfg_data;
        CFG_SWITCH_DELAY: switch_delay_nxt = cfg_data;
        default: ;
      endcase
    end

    // Saturating useful-count increment on a line hit.
    if (hit && (cnt_cur != '1)) begin
      useful_nxt[cnt_idx] = cnt_cur + 1'b1;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          dec_nxt  = 1'b0;
          addr_nxt = in_data.address;
          if (in_data.op == OP_TARGET) begin
            if (pending_r && in_src_ok && (32'(fill_cur) < TARGETS_PER_SOURCE)) begin
              wr_en            = 1'b1;
              fill_nxt[in_sid] = fill_cur + 1'b1;
            end
            state_nxt = ST_FINISH;
          end else begin
            access_count_nxt = access_count_r + 1'b1;
            scan_s_nxt       = '0;
            scan_i_nxt       = '0;
            state_nxt        = pending_r ? ST_SCAN : ST_WIN;
          end
        end
      end
      ST_SCAN: begin
        rd_en        = 1'b1;
        pipe_vld_nxt = 1'b1;
        pipe_src_nxt = scan_s_r;
        pipe_ok_nxt  = (32'(scan_i_r) < 32'(fill_cur));
        if (scan_i_r == IDX_W'(TARGETS_PER_SOURCE - 1)) begin
          scan_i_nxt = '0;
          if (scan_s_r == SID_W'(NUM_SOURCES - 1)) begin
            state_nxt = ST_DRAIN;
          end else begin
            scan_s_nxt = scan_s_r + 1'b1;
          end
        end else begin
          scan_i_nxt = scan_i_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_WIN;
      end
      ST_WIN: begin
        if (access_count_r >= window_size_r) begin
          pending_nxt      = 1'b1;
          access_count_nxt = '0;
          for (int s = 0; s < NUM_SOURCES; s++) begin
            fill_nxt[s] = '0;
          end
          dsrc_nxt  = '0;
          state_nxt = ST_DEC_START;
        end else begin
          state_nxt = ST_SELECT;
        end
      end
      ST_DEC_START: begin
        div_start = 1'b1;
        state_nxt = ST_DEC_WAIT;
      end
      ST_DEC_WAIT: begin
        if (div_stat.done) begin
          useful_nxt[dsrc_r] = div_quot;
          if (dsrc_r == SID_W'(NUM_SOURCES - 1)) begin
            state_nxt = ST_SELECT;
          end else begin
            dsrc_nxt  = dsrc_r + 1'b1;
            state_nxt = ST_DEC_START;
          end
        end
      end
      ST_SELECT: begin
        if (pending_r && (access_count_r >= switch_delay_r)) begin
          selected_nxt = best_idx;
          pending_nxt  = 1'b0;
          dec_nxt      = 1'b1;
        end
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.chosen     = selected_r;
          out_data_nxt.decided    = dec_r;
          out_data_nxt.evaluating = pending_r;
          state_nxt               = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      access_count_r <= '0;
      pending_r      <= 1'b0;
      selected_r     <= '0;
      for (int s = 0; s < NUM_SOURCES; s++) begin
        useful_r[s] <= '0;
        fill_r[s]   <= '0;
      end
      scan_s_r       <= '0;
      scan_i_r       <= '0;
      pipe_vld_r     <= 1'b0;
      dsrc_r         <= '0;
      dec_r          <= 1'b0;
      window_size_r  <= REG_W'(1024);
      switch_delay_r <= REG_W'(128);
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      access_count_r <= access_count_nxt;
      pending_r      <= pending_nxt;
      selected_r     <= selected_nxt;
      useful_r       <= useful_nxt;
      fill_r         <= fill_nxt;
      scan_s_r       <= scan_s_nxt;
      scan_i_r       <= scan_i_nxt;
      pipe_vld_r     <= pipe_vld_nxt;
      dsrc_r         <= dsrc_nxt;
      dec_r          <= dec_nxt;
      window_size_r  <= window_size_nxt;
      switch_delay_r <= switch_delay_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    pipe_src_r <= pipe_src_nxt;
    pipe_ok_r  <= pipe_ok_nxt;
    out_data_r <= out_data_nxt;
  end

  cps_target_buf u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_data.address),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  cps_decay_unit u_decay (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .value    (useful_r[dsrc_r]),
    .stat     (div_stat),
    .quotient (div_quot)
  );

endmodule

`default_nettype wire

FILE: dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cps_pkg::*;

  // Cycles without any handshake before the run is declared hung.
  localparam int HANG_LIMIT = 2000;
  // Worst single access: full target scan plus the decay of every count.
  localparam int SETTLE_CYCLES = MEM_DEPTH + 5 + NUM_SOURCES * 3 + 16;
  localparam int PHASE_BEATS = 50;

  typedef enum int {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PERIODIC,
    STALL_BURST
  } stall_mode_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  cps_in_t              in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  cps_out_t             out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0]     cfg_data  = '0;

  coverage_prefetcher_selector_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Shadow copy of the selector state and its registers.
  logic [REG_W-1:0]     win_len;
  logic [REG_W-1:0]     dly_len;
  logic [15:0]          access_cnt;
  logic                 eval_pending;
  logic [1:0]           sel_idx;
  logic [COUNT_W-1:0]   hits [NUM_SOURCES];
  logic [ADDR_BITS-1:0] tgt_buf [NUM_SOURCES][TARGETS_PER_SOURCE];
  int                   tgt_fill [NUM_SOURCES];

  // Selections still owed by the block, oldest first.
  cps_out_t choice_q [$];
  cps_out_t want;

  int mismatches      = 0;
  int beats_sent      = 0;
  int decisions_seen  = 0;
  int dropped_targets = 0;
  int cfg_writes      = 0;
  int burst_left      = 0;
  int idle_cycles     = 0;
  int cycle_cnt       = 0;
  stall_mode_t stall_mode = STALL_NONE;

  task automatic reset_selector_model();
    win_len      = 16'd1024;
    dly_len      = 16'd128;
    access_cnt   = '0;
    eval_pending = 1'b0;
    sel_idx      = '0;
    for (int s = 0; s < NUM_SOURCES; s++) begin
      hits[s]     = '0;
      tgt_fill[s] = 0;
    end
  endtask

  // Applies one beat to the shadow state and returns the result it must produce.
  function automatic cps_out_t advance_selector(cps_in_t beat);
    cps_out_t           res;
    logic [COUNT_W-1:0] best;
    int                 src;
    res = '0;
    src = beat.source_index;
    if (beat.op == OP_TARGET) begin
      // Targets are kept only during an evaluation and only while there is room.
      if (eval_pending && src < NUM_SOURCES) begin
        if (tgt_fill[src] < TARGETS_PER_SOURCE) begin
          tgt_buf[src][tgt_fill[src]] = beat.address;
          tgt_fill[src]++;
        end else begin
          dropped_targets++;
        end
      end
    end else begin
      access_cnt = access_cnt + 16'd1;
      // Credit every buffered target whose line holds the address.
      if (eval_pending) begin
        for (int s = 0; s < NUM_SOURCES; s++) begin
          for (int i = 0; i < tgt_fill[s]; i++) begin
            if (beat.address >= tgt_buf[s][i] &&
                (beat.address - tgt_buf[s][i]) < ADDR_BITS'(LINE_BYTES) &&
                hits[s] != '1) begin
              hits[s] = hits[s] + 1'b1;
            end
          end
        end
      end
      // Window end: decay the counts, empty the buffers, open an evaluation.
      if (access_cnt >= win_len) begin
        eval_pending = 1'b1;
        access_cnt   = '0;
        for (int s = 0; s < NUM_SOURCES; s++) begin
          hits[s]     = hits[s] / COUNT_W'(DECAY_DIV);
          tgt_fill[s] = 0;
        end
      end
      // Strictly greatest nonzero count wins; ties go to the lower index.
      if (eval_pending && access_cnt >= dly_len) begin
        best = '0;
        for (int s = 0; s < NUM_SOURCES; s++) begin
          if (hits[s] > best) begin
            best    = hits[s];
            sel_idx = 2'(s);
          end
        end
        eval_pending = 1'b0;
        res.decided  = 1'b1;
      end
    end
    res.chosen     = sel_idx;
    res.evaluating = eval_pending;
    return res;
  endfunction

  // Sends one beat, opening a new burst after a random gap when the last one ran out.
  task automatic send_beat(input cps_in_t beat);
    int       gap;
    cps_out_t res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
    res = advance_selector(beat);
    choice_q = {choice_q, res};
    beats_sent++;
  endtask

  task automatic send_item(input logic op, input int src, input logic [ADDR_BITS-1:0] addr);
    cps_in_t beat;
    beat.op           = op;
    beat.source_index = 2'(src);
    beat.address      = addr;
    send_beat(beat);
  endtask

  // Waits until every owed result has come back and the block is quiet.
  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    while (choice_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_WINDOW_SIZE) begin
      win_len = value;
    end else begin
      dly_len = value;
    end
    cfg_writes++;
  endtask

  // Mostly well-formed evaluations: targets near one region, then accesses that
  // land inside or just past their lines, with some fully random noise.
  task automatic run_random_phase(input int win, input int dly, input int n_items);
    cps_in_t              beat;
    logic [ADDR_BITS-1:0] region;
    int                   counted;
    int                   focus;
    int                   roll;
    int                   src;
    counted = 0;
    set_register(CFG_WINDOW_SIZE, REG_W'(win));
    set_register(CFG_SWITCH_DELAY, REG_W'(dly));
    region = ADDR_BITS'({$urandom, $urandom});
    focus  = $urandom_range(0, NUM_SOURCES - 1);
    while (counted < n_items) begin
      beat.op           = OP_ACCESS;
      beat.source_index = 2'($urandom_range(0, 3));
      beat.address      = region + ADDR_BITS'($urandom_range(0, 63));
      roll = $urandom_range(0, 99);
      if (eval_pending) begin
        if (roll < 45) begin
          beat.op = OP_TARGET;
          if ($urandom_range(0, 1) == 1) beat.source_index = 2'(focus);
        end else if (roll < 90) begin
          src = $urandom_range(0, NUM_SOURCES - 1);
          if (tgt_fill[src] > 0) begin
            beat.address = tgt_buf[src][$urandom_range(0, tgt_fill[src] - 1)] +
                           ADDR_BITS'($urandom_range(0, 9));
          end
        end else begin
          beat.address = ADDR_BITS'({$urandom, $urandom});
        end
      end else if (roll < 15) begin
        beat.op = OP_TARGET;
      end else if (roll < 30) begin
        beat.address = ADDR_BITS'({$urandom, $urandom});
      end
      // A target sent outside an evaluation is simply ignored by the block.
      if (eval_pending || beat.op == OP_ACCESS) counted++;
      send_beat(beat);
    end
  endtask

  // Reset register values: no window can end within a few accesses.
  task automatic test_reset_defaults();
    send_item(OP_ACCESS, 0, '0);
    send_item(OP_TARGET, 3, '1);
    send_item(OP_ACCESS, 1, '1);
  endtask

  // Zero window and zero delay: every access ends a window and decides at once.
  task automatic test_zero_window();
    set_register(CFG_WINDOW_SIZE, '0);
    set_register(CFG_SWITCH_DELAY, '0);
    send_item(OP_ACCESS, 2, ADDR_BITS'({$urandom, $urandom}));
    send_item(OP_TARGET, 2, ADDR_BITS'(64));
    send_item(OP_ACCESS, 3, ADDR_BITS'(64));
  endtask

  // Targets at both address extremes, line hits at the top end, a three-way tie and a decay to zero.
  task automatic test_scoring();
    set_register(CFG_WINDOW_SIZE, 16'd4);
    set_register(CFG_SWITCH_DELAY, 16'd2);
    repeat (4) send_item(OP_ACCESS, 0, ADDR_BITS'({$urandom, $urandom}));
    send_item(OP_TARGET, 0, '0);
    send_item(OP_TARGET, 1, {{(ADDR_BITS-3){1'b1}}, 3'b000});
    send_item(OP_TARGET, 2, '1);
    send_item(OP_TARGET, 3, ADDR_BITS'(16));
    send_item(OP_ACCESS, 0, '1);
    send_item(OP_ACCESS, 0, ADDR_BITS'(23));
    repeat (4) send_item(OP_ACCESS, 0, ADDR_BITS'({$urandom, $urandom}));
  endtask

  task automatic test_register_extremes();
    run_random_phase(65535, 65535, 8);
    run_random_phase(0, 65535, 8);
  endtask

  task automatic test_random_traffic();
    int win_opts [8] = '{1, 2, 6, 8, 12, 30, 4, 16};
    int dly_opts [8] = '{0, 1, 3, 8, 6, 20, 65535, 0};
    int w;
    for (int p = 0; p < 8; p++) begin
      run_random_phase(win_opts[p], dly_opts[p], PHASE_BEATS);
    end
    repeat (2) begin
      w = $urandom_range(1, 24);
      run_random_phase(w, $urandom_range(0, w), PHASE_BEATS);
    end
  endtask

  initial begin
    reset_selector_model();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_zero_window();
    test_scoring();
    test_register_extremes();
    test_random_traffic();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d beats over %0d register writes; %0d selections, %0d targets dropped.",
             beats_sent, cfg_writes, decisions_seen, dropped_targets);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  function automatic void check_field(input string name, input logic [1:0] exp_v,
                                      input logic [1:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // Each result beat is matched against the oldest owed selection.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (choice_q.size() == 0) begin
        $display("%0t: result beat with nothing expected, actual chosen %0d decided %0b",
                 $time, out_data.chosen, out_data.decided);
        mismatches++;
      end else begin
        want = choice_q.pop_front();
        check_field("chosen", want.chosen, out_data.chosen);
        check_field("decided", {1'b0, want.decided}, {1'b0, out_data.decided});
        check_field("evaluating", {1'b0, want.evaluating}, {1'b0, out_data.evaluating});
        if (want.decided) decisions_seen++;
      end
    end
  end

  // Receiver backpressure changes character: the stall mode is picked anew at random.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt % 64 == 0) stall_mode <= stall_mode_t'($urandom_range(0, 3));
    case (stall_mode)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_RANDOM:   out_stall <= ($urandom_range(0, 9) < 4);
      STALL_PERIODIC: out_stall <= (cycle_cnt % 3 == 0);
      default:        out_stall <= cycle_cnt[3];
    endcase
  end

  // Hang detection: any handshake restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == HANG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding",
               $time, HANG_LIMIT, choice_q.size());
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
